// ===== sv/crtsu_pkg.sv =====
// shared types, codes and helper functions of the scanline upscaler
package crtsu_pkg;

   // transaction kinds on the request channel
   localparam logic REQ_TABLE = 1'b0;
   localparam logic REQ_PIXEL = 1'b1;

   // table select codes
   localparam logic [2:0] SEL_MAIN_RED   = 3'd0;
   localparam logic [2:0] SEL_MAIN_GREEN = 3'd1;
   localparam logic [2:0] SEL_MAIN_BLUE  = 3'd2;
   localparam logic [2:0] SEL_SCAN_RED   = 3'd3;
   localparam logic [2:0] SEL_SCAN_GREEN = 3'd4;
   localparam logic [2:0] SEL_SCAN_BLUE  = 3'd5;

   // register indexes
   localparam logic [2:0] CSR_RED_LOW    = 3'd0;
   localparam logic [2:0] CSR_GREEN_LOW  = 3'd1;
   localparam logic [2:0] CSR_BLUE_LOW   = 3'd2;
   localparam logic [2:0] CSR_RED_HIGH   = 3'd3;
   localparam logic [2:0] CSR_GREEN_HIGH = 3'd4;
   localparam logic [2:0] CSR_BLUE_HIGH  = 3'd5;

   localparam logic [9:0] LOW_GAIN_RESET  = 10'd256;
   localparam logic [9:0] HIGH_GAIN_RESET = 10'd282;

   localparam int QUEUE_DEPTH = 2;

   // per-channel gains, index 0 red, 1 green, 2 blue
   typedef struct packed {
      logic [2:0][9:0] low;
      logic [2:0][9:0] high;
   } gains_type;

   // one unit of work handed from front to back
   typedef struct packed {
      logic            is_write;
      logic [1:0]      wr_chan;
      logic [7:0]      wr_addr;
      logic [7:0]      wr_value;
      logic            pair_valid;
      logic            tail_valid;
      logic [3:0][2:0][7:0] lin;    // columns: pair l0, pair l1, tail l0, tail l1
      logic [3:0][1:0] grille;
   } job_type;

   // grille color of the even or odd column of a pair at a given phase
   function automatic logic [1:0] grille_of(input logic [1:0] phase, input logic odd);
      logic [1:0] g;
      case (phase)
         2'd0:    g = odd ? 2'd1 : 2'd0;
         2'd1:    g = odd ? 2'd0 : 2'd2;
         2'd2:    g = odd ? 2'd2 : 2'd1;
         default: g = 2'd0;
      endcase
      return g;
   endfunction

   function automatic logic [1:0] phase_inc(input logic [1:0] phase);
      return (phase == 2'd2) ? 2'd0 : phase + 2'd1;
   endfunction

endpackage

// ===== sv/crtsu_if.sv =====
// channel interfaces: request, response and register write
interface crtsu_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [2:0] table_select;
   logic [7:0] table_index;
   logic [7:0] table_value;
   logic [7:0] pixel_red;
   logic [7:0] pixel_green;
   logic [7:0] pixel_blue;
   logic       row_end;
   modport source(output valid, req_type, table_select, table_index, table_value,
                  pixel_red, pixel_green, pixel_blue, row_end, input ready);
   modport sink(input valid, req_type, table_select, table_index, table_value,
                pixel_red, pixel_green, pixel_blue, row_end, output ready);
endinterface

interface crtsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic       scan_row;
   logic       run_last;
   modport source(output valid, out_red, out_green, out_blue, scan_row, run_last,
                  input ready);
   modport sink(input valid, out_red, out_green, out_blue, scan_row, run_last,
                output ready);
endinterface

interface crtsu_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] reg_index;
   logic [9:0] write_data;
   modport source(output valid, reg_index, write_data, input ready);
   modport sink(input valid, reg_index, write_data, output ready);
endinterface

// ===== sv/crtsu_front.sv =====
// front end: main level tables, pair blending and job building
module crtsu_front
   import crtsu_pkg::*;
#(
   parameter int TABLE_DEPTH = 256
) (
   input  logic    clock,
   input  logic    reset,
   crtsu_req_if.sink req_bus,
   output logic    push,
   output job_type push_job,
   input  logic    queue_full
);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [8:0] DEPTH9 = 9'(TABLE_DEPTH);
   localparam logic [7:0] LAST_IDX = 8'(TABLE_DEPTH - 1);

   logic accept;
   logic s1_fire;
   logic need_push;
   logic idx_ok;

   // stage one registers
   logic       s1_valid_ff, s1_valid_in;
   logic       s1_type_ff;
   logic [2:0] s1_sel_ff;
   logic [7:0] s1_idx_ff;
   logic [7:0] s1_value_ff;
   logic       s1_row_end_ff;

   // row state
   logic [2:0][7:0] held_ff, held_in;
   logic            holding_ff, holding_in;
   logic [1:0]      phase_ff, phase_in;

   logic [2:0][7:0] rd_ff;
   logic [2:0][7:0] pix;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !s1_valid_ff || s1_fire;
   assign idx_ok        = {1'b0, req_bus.table_index} < DEPTH9;
   assign pix           = {req_bus.pixel_blue, req_bus.pixel_green, req_bus.pixel_red};

   // main tables, one memory per channel with registered read
   for (genvar c = 0; c < 3; c++) begin : g_main
      logic [7:0] mem [TABLE_DEPTH];
      logic [7:0] look_idx;
      assign look_idx = ({1'b0, pix[c]} >= DEPTH9) ? LAST_IDX : pix[c];
      always_ff @(posedge clock) begin
         if (accept && req_bus.req_type == REQ_TABLE && idx_ok &&
             req_bus.table_select == 3'(c)) begin
            mem[req_bus.table_index[ADDR_W-1:0]] <= req_bus.table_value;
         end
         if (accept && req_bus.req_type == REQ_PIXEL) begin
            rd_ff[c] <= mem[look_idx[ADDR_W-1:0]];
         end
      end
   end

   // stage one capture
   assign s1_valid_in = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_type_ff    <= req_bus.req_type;
         s1_sel_ff     <= req_bus.table_select;
         s1_idx_ff     <= req_bus.table_index;
         s1_value_ff   <= req_bus.table_value;
         s1_row_end_ff <= req_bus.row_end;
      end
   end

   // job building
   logic [1:0] tail_phase;
   logic       scan_write;
   assign scan_write = (s1_sel_ff == SEL_SCAN_RED || s1_sel_ff == SEL_SCAN_GREEN ||
                        s1_sel_ff == SEL_SCAN_BLUE) && ({1'b0, s1_idx_ff} < DEPTH9);
   assign tail_phase = holding_ff ? phase_inc(phase_ff) : phase_ff;

   always_comb begin
      logic [8:0] sum;
      push_job            = '0;
      push_job.is_write   = (s1_type_ff == REQ_TABLE);
      push_job.wr_chan    = 2'(s1_sel_ff - SEL_SCAN_RED);
      push_job.wr_addr    = s1_idx_ff;
      push_job.wr_value   = s1_value_ff;
      push_job.pair_valid = holding_ff;
      push_job.tail_valid = s1_row_end_ff;
      for (int c = 0; c < 3; c++) begin
         push_job.lin[0][c] = (held_ff[c] >> 1) + (rd_ff[c] >> 1);
         sum = {1'b0, push_job.lin[0][c]} + {1'b0, rd_ff[c]};
         push_job.lin[1][c] = sum[8:1];
         push_job.lin[2][c] = rd_ff[c] >> 1;
         push_job.lin[3][c] = rd_ff[c] >> 2;
      end
      push_job.grille[0] = grille_of(phase_ff, 1'b0);
      push_job.grille[1] = grille_of(phase_ff, 1'b1);
      push_job.grille[2] = grille_of(tail_phase, 1'b0);
      push_job.grille[3] = grille_of(tail_phase, 1'b1);
   end

   assign need_push = (s1_type_ff == REQ_TABLE) ? scan_write
                                                : (holding_ff || s1_row_end_ff);
   assign s1_fire   = s1_valid_ff && (!need_push || !queue_full);
   assign push      = s1_valid_ff && need_push && !queue_full;

   // row state update on pixels
   always_comb begin
      held_in    = held_ff;
      holding_in = holding_ff;
      phase_in   = phase_ff;
      if (s1_fire && s1_type_ff == REQ_PIXEL) begin
         held_in    = s1_row_end_ff ? '0 : rd_ff;
         holding_in = !s1_row_end_ff;
         phase_in   = s1_row_end_ff ? 2'd0 : (holding_ff ? phase_inc(phase_ff) : phase_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         holding_ff <= 1'b0;
         phase_ff   <= 2'd0;
      end else begin
         held_ff    <= held_in;
         holding_ff <= holding_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

// ===== sv/crtsu_queue.sv =====
// short job queue between front and back
module crtsu_queue
   import crtsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from empty queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance");
`endif

endmodule

// ===== sv/crtsu_back.sv =====
// back end: gain scaling, scanline lookup and output sequencing
module crtsu_back
   import crtsu_pkg::*;
#(
   parameter int CHANNEL_MAX = 255,
   parameter int TABLE_DEPTH = 256
) (
   input  logic      clock,
   input  logic      reset,
   input  gains_type gains,
   input  logic      head_valid,
   input  job_type   head_job,
   output logic      pop,
   crtsu_rsp_if.source rsp_bus
);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam logic [8:0] DEPTH9 = 9'(TABLE_DEPTH);
   localparam logic [7:0] LAST_IDX = 8'(TABLE_DEPTH - 1);
   localparam logic [9:0] SAT10 = 10'(CHANNEL_MAX);

   logic [2:0] step_ff, step_in;
   logic [2:0] eff_step;
   logic [2:0] last_step;
   logic       is_last;
   logic       load;
   logic       do_write;
   logic [1:0] col;

   logic            rsp_valid_ff, rsp_valid_in;
   logic [2:0][7:0] rsp_pix_ff;
   logic            rsp_scan_ff;
   logic            rsp_last_ff;

   logic [2:0][7:0] main_pix;
   logic [2:0][7:0] scan_rd_ff;

   assign eff_step  = head_job.pair_valid ? step_ff : step_ff + 3'd4;
   assign last_step = head_job.tail_valid ? 3'd7 : 3'd3;
   assign is_last   = (eff_step == last_step);
   assign col       = eff_step[2:1];
   assign do_write  = head_valid && head_job.is_write;
   assign load      = head_valid && !head_job.is_write && (!rsp_valid_ff || rsp_bus.ready);
   assign pop       = do_write || (load && is_last);

   // gain scaling with saturation
   always_comb begin
      logic [9:0]  g;
      logic [17:0] prod;
      for (int c = 0; c < 3; c++) begin
         g    = (head_job.grille[col] == 2'(c)) ? gains.high[c] : gains.low[c];
         prod = {10'd0, head_job.lin[col][c]} * {8'd0, g};
         main_pix[c] = (prod[17:8] > SAT10) ? SAT10[7:0] : prod[15:8];
      end
   end

   // scanline tables, one memory per channel
   for (genvar c = 0; c < 3; c++) begin : g_scan
      logic [7:0] mem [TABLE_DEPTH];
      logic [7:0] look_idx;
      assign look_idx = ({1'b0, main_pix[c]} >= DEPTH9) ? LAST_IDX : main_pix[c];
      always_ff @(posedge clock) begin
         if (do_write && head_job.wr_chan == 2'(c)) begin
            mem[head_job.wr_addr[ADDR_W-1:0]] <= head_job.wr_value;
         end
         if (load && !eff_step[0]) begin
            scan_rd_ff[c] <= mem[look_idx[ADDR_W-1:0]];
         end
      end
   end

   // step counter within a job
   always_comb begin
      step_in = step_ff;
      if (load) begin
         step_in = is_last ? 3'd0 : step_ff + 3'd1;
      end
   end

   // output register
   assign rsp_valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         rsp_pix_ff  <= eff_step[0] ? scan_rd_ff : main_pix;
         rsp_scan_ff <= eff_step[0];
         rsp_last_ff <= is_last;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.out_red   = rsp_pix_ff[0];
   assign rsp_bus.out_green = rsp_pix_ff[1];
   assign rsp_bus.out_blue  = rsp_pix_ff[2];
   assign rsp_bus.scan_row  = rsp_scan_ff;
   assign rsp_bus.run_last  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_scan_follows_main: assert property (@(posedge clock) disable iff (reset)
      (load && !eff_step[0]) |=> (step_ff != 3'd0))
      else $error("main pixel not followed by scanline pixel");
   a_last_is_scan: assert property (@(posedge clock) disable iff (reset)
      (load && is_last) |-> eff_step[0])
      else $error("run ended on a main pixel");
   a_idle_step: assert property (@(posedge clock) disable iff (reset)
      do_write |-> (step_ff == 3'd0))
      else $error("table write in the middle of a pixel run");
`endif

endmodule

// ===== sv/crt_scanline_upscale_2x.sv =====
// top level of the scanline upscaler: gain registers and front/queue/back wiring
//
//   channel   dir   handshake      carries
//   req_bus   in    valid/ready    table write or pixel
//   rsp_bus   out   valid/ready    output pixel, scan_row, run_last
//   csr_bus   in    valid/ready    gain register write
//
// a pixel that completes a pair gives 4 output pixels, 8 when it
// also ends the row; a one-pixel row gives 4; the first pixel of a longer row
// and a table write give nothing.
// first output pixel path: stage one registers, job queue, output register.
// reset clears control state and sets the gains to their reset values; level tables
// hold nothing until written, there is no clearing pass.
// front and back stall independently through a two-entry job queue.
module crt_scanline_upscale_2x
   import crtsu_pkg::*;
#(
   parameter int CHANNEL_MAX = 255,
   parameter int TABLE_DEPTH = 256
) (
   input  logic clock,
   input  logic reset,
   crtsu_req_if.sink   req_bus,
   crtsu_rsp_if.source rsp_bus,
   crtsu_csr_if.sink   csr_bus
);
   gains_type gains_ff, gains_in;
   logic      push, queue_full, pop, head_valid;
   job_type   push_job, head_job;

   // gain registers
   assign csr_bus.ready = 1'b1;
   always_comb begin
      gains_in = gains_ff;
      if (csr_bus.valid) begin
         case (csr_bus.reg_index)
            CSR_RED_LOW:    gains_in.low[0]  = csr_bus.write_data;
            CSR_GREEN_LOW:  gains_in.low[1]  = csr_bus.write_data;
            CSR_BLUE_LOW:   gains_in.low[2]  = csr_bus.write_data;
            CSR_RED_HIGH:   gains_in.high[0] = csr_bus.write_data;
            CSR_GREEN_HIGH: gains_in.high[1] = csr_bus.write_data;
            CSR_BLUE_HIGH:  gains_in.high[2] = csr_bus.write_data;
            default:        gains_in = gains_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_ff.low  <= {3{LOW_GAIN_RESET}};
         gains_ff.high <= {3{HIGH_GAIN_RESET}};
      end else begin
         gains_ff <= gains_in;
      end
   end

   crtsu_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .push       (push),
      .push_job   (push_job),
      .queue_full (queue_full)
   );

   crtsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   crtsu_back #(.CHANNEL_MAX(CHANNEL_MAX), .TABLE_DEPTH(TABLE_DEPTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .gains      (gains_ff),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

// ===== tb/sv/crt_scanline_upscale_2x_tb.sv =====
// testbench of the scanline upscaler: queued stimulus, pixel predictor, response checker
module crt_scanline_upscale_2x_tb;
   import crtsu_pkg::*;

   typedef struct {
      logic       kind;
      logic [2:0] sel;
      logic [7:0] idx;
      logic [7:0] val;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
   } req_item_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       scan_row;
      logic       run_last;
   } out_pixel_type;

   localparam int IDLE_CYCLES = 20;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD = 400;

   logic clock;
   logic reset;

   crtsu_req_if req_bus ();
   crtsu_rsp_if rsp_bus ();
   crtsu_csr_if csr_bus ();

   crt_scanline_upscale_2x u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   // model state
   logic [7:0] level_tbl [6][256];
   logic [7:0] held [3];
   logic       holding;
   int         col_phase;
   logic [9:0] low_gain [3];
   logic [9:0] high_gain [3];

   req_item_type  pending_q [$];
   out_pixel_type expected_px [$];
   int         errors = 0;
   int         rx_count = 0;
   int         idle_count = 0;
   logic       req_fire = 1'b0;
   int         burst_left = 0;
   int         gap_left = 0;

   // clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   task automatic report(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, rx_count);
      errors++;
   endtask

   // one blended column: main pixel then its scanline pixel
   function automatic void emit_column(input int lin [3], input int grille);
      out_pixel_type m, s;
      int v [3];
      for (int c = 0; c < 3; c++) begin
         int g;
         g = (c == grille) ? high_gain[c] : low_gain[c];
         v[c] = (lin[c] * g) >> 8;
         if (v[c] > 255) v[c] = 255;
      end
      m.red = v[0]; m.green = v[1]; m.blue = v[2];
      m.scan_row = 1'b0; m.run_last = 1'b0;
      s.red = level_tbl[SEL_SCAN_RED][v[0]];
      s.green = level_tbl[SEL_SCAN_GREEN][v[1]];
      s.blue = level_tbl[SEL_SCAN_BLUE][v[2]];
      s.scan_row = 1'b1; s.run_last = 1'b0;
      expected_px.push_back(m);
      expected_px.push_back(s);
   endfunction

   function automatic void emit_pair(input int l0 [3], input int l1 [3]);
      emit_column(l0, (2 * col_phase) % 3);
      emit_column(l1, (2 * col_phase + 1) % 3);
   endfunction

   // upscale prediction for one accepted transaction
   function automatic void predict_upscale(input req_item_type it);
      int cur [3], l0 [3], l1 [3];
      int start_count;
      start_count = expected_px.size();
      if (it.kind == REQ_TABLE) begin
         if (it.sel <= SEL_SCAN_BLUE) level_tbl[it.sel][it.idx] = it.val;
         return;
      end
      cur[0] = level_tbl[SEL_MAIN_RED][it.red];
      cur[1] = level_tbl[SEL_MAIN_GREEN][it.green];
      cur[2] = level_tbl[SEL_MAIN_BLUE][it.blue];
      if (holding) begin
         for (int c = 0; c < 3; c++) begin
            l0[c] = (held[c] >> 1) + (cur[c] >> 1);
            l1[c] = (l0[c] + cur[c]) >> 1;
         end
         emit_pair(l0, l1);
         col_phase = (col_phase + 1) % 3;
      end
      for (int c = 0; c < 3; c++) held[c] = cur[c];
      holding = 1'b1;
      if (it.row_end) begin
         for (int c = 0; c < 3; c++) begin
            l0[c] = cur[c] >> 1;
            l1[c] = cur[c] >> 2;
         end
         emit_pair(l0, l1);
         holding = 1'b0;
         col_phase = 0;
         for (int c = 0; c < 3; c++) held[c] = 8'd0;
      end
      if (expected_px.size() > start_count)
         expected_px[expected_px.size() - 1].run_last = 1'b1;
   endfunction

   // acceptance capture and watchdog
   always @(posedge clock) begin
      req_fire <= req_bus.valid && req_bus.ready && !reset;
      if (!reset && ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
                     || (csr_bus.valid && csr_bus.ready)))
         idle_count <= 0;
      else if (!reset) idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_px.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // request driver: bursts and gaps
   always @(negedge clock) begin
      if (req_fire) begin
         predict_upscale(pending_q[0]);
         pending_q.pop_front();
      end
      if (reset || (req_bus.valid && !req_fire)) begin
         // hold current offer
      end else if (gap_left > 0) begin
         req_bus.valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_q.size() > 0) begin
         req_bus.valid <= 1'b1;
         req_bus.req_type <= pending_q[0].kind;
         req_bus.table_select <= pending_q[0].sel;
         req_bus.table_index <= pending_q[0].idx;
         req_bus.table_value <= pending_q[0].val;
         req_bus.pixel_red <= pending_q[0].red;
         req_bus.pixel_green <= pending_q[0].green;
         req_bus.pixel_blue <= pending_q[0].blue;
         req_bus.row_end <= pending_q[0].row_end;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // response ready: stall pattern plus one long hold-off
   int   mode_left = 0;
   int   rx_mode = 0;
   int   hold_left = 0;
   logic long_done = 1'b0;
   always @(negedge clock) begin
      if (!long_done && rx_count >= 300) begin
         long_done <= 1'b1;
         hold_left <= LONG_HOLD;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(10, 80);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (rx_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_px.size() == 0) begin
            report("unexpected result", rsp_bus.out_red, 0);
         end else begin
            out_pixel_type e;
            e = expected_px.pop_front();
            if (rsp_bus.out_red !== e.red) report("out_red", rsp_bus.out_red, e.red);
            if (rsp_bus.out_green !== e.green) report("out_green", rsp_bus.out_green, e.green);
            if (rsp_bus.out_blue !== e.blue) report("out_blue", rsp_bus.out_blue, e.blue);
            if (rsp_bus.scan_row !== e.scan_row)
               report("scan_row", rsp_bus.scan_row, e.scan_row);
            if (rsp_bus.run_last !== e.run_last)
               report("run_last", rsp_bus.run_last, e.run_last);
         end
         rx_count <= rx_count + 1;
      end
   end

   function automatic req_item_type table_item(input int sel, input int idx, input int val);
      req_item_type it;
      it = '{kind: REQ_TABLE, sel: sel, idx: idx, val: val, red: $urandom, green: $urandom,
             blue: $urandom, row_end: $urandom};
      return it;
   endfunction

   function automatic req_item_type pixel_item(input int r, input int g, input int b,
                                               input logic last);
      req_item_type it;
      it = '{kind: REQ_PIXEL, sel: $urandom, idx: $urandom, val: $urandom, red: r,
             green: g, blue: b, row_end: last};
      return it;
   endfunction

   // random traffic: mostly rows of pixels, some table rewrites and ignored selects
   task automatic queue_random(input int n);
      for (int i = 0; i < n; i++) begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 84)
            pending_q.push_back(pixel_item($urandom, $urandom, $urandom,
                                           $urandom_range(0, 5) == 0));
         else if (pick < 95)
            pending_q.push_back(table_item($urandom_range(0, 5), $urandom, $urandom));
         else
            pending_q.push_back(table_item($urandom_range(6, 7), $urandom, $urandom));
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_q.size() > 0 || req_bus.valid || expected_px.size() > 0);
      repeat (IDLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_gain(input logic [2:0] idx, input logic [9:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.reg_index <= idx;
      csr_bus.write_data <= data;
      do @(posedge clock);
      while (!csr_bus.ready);
      if (idx <= CSR_BLUE_LOW) low_gain[idx] = data;
      else high_gain[idx - CSR_RED_HIGH] = data;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_all_gains(input int lo, input int hi);
      write_gain(CSR_RED_LOW, lo);
      write_gain(CSR_GREEN_LOW, lo);
      write_gain(CSR_BLUE_LOW, lo);
      write_gain(CSR_RED_HIGH, hi);
      write_gain(CSR_GREEN_HIGH, hi);
      write_gain(CSR_BLUE_HIGH, hi);
   endtask

   // stimulus sequence
   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0; req_bus.req_type = REQ_TABLE; req_bus.table_select = 3'd0;
      req_bus.table_index = 8'd0; req_bus.table_value = 8'd0; req_bus.pixel_red = 8'd0;
      req_bus.pixel_green = 8'd0; req_bus.pixel_blue = 8'd0; req_bus.row_end = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0; csr_bus.reg_index = CSR_RED_LOW; csr_bus.write_data = 10'd0;
      holding = 1'b0; col_phase = 0;
      for (int c = 0; c < 3; c++) begin
         held[c] = 8'd0;
         low_gain[c] = LOW_GAIN_RESET;
         high_gain[c] = HIGH_GAIN_RESET;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill every table entry so that no lookup reads an unwritten word
      for (int s = SEL_MAIN_RED; s <= SEL_SCAN_BLUE; s++)
         for (int i = 0; i < 256; i++)
            pending_q.push_back(table_item(s, i, (i == 255) ? 255 : (i == 0) ? 0 : $urandom));

      // directed: extremes, one-pixel rows, phase wrap, ignored selects
      pending_q.push_back(pixel_item(0, 0, 0, 1'b1));
      pending_q.push_back(pixel_item(255, 255, 255, 1'b1));
      pending_q.push_back(pixel_item(255, 0, 255, 1'b0));
      pending_q.push_back(pixel_item(0, 255, 0, 1'b1));
      for (int i = 0; i < 5; i++) pending_q.push_back(pixel_item(255, 255, 255, i == 4));
      pending_q.push_back(table_item(6, 8'd255, 8'd255));
      pending_q.push_back(table_item(7, 8'd0, 8'd0));
      for (int i = 0; i < 4; i++) pending_q.push_back(pixel_item(0, 128, 255, i == 3));
      pending_q.push_back(table_item(SEL_SCAN_GREEN, 8'd255, 8'd0));
      pending_q.push_back(pixel_item(255, 255, 255, 1'b1));
      wait_drained();

      // gain extremes, reset values and random settings, each followed by random rows
      write_all_gains(0, 0);
      queue_random(30);
      wait_drained();
      write_all_gains(1023, 1023);
      queue_random(40);
      wait_drained();
      write_all_gains(LOW_GAIN_RESET, HIGH_GAIN_RESET);
      queue_random(80);
      wait_drained();
      for (int i = CSR_RED_LOW; i <= CSR_BLUE_HIGH; i++) write_gain(i, $urandom);
      queue_random(60);
      wait_drained();

      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
